FILE: hdl/rbsi_pkg.sv
// Shared types and constants for the ray/box slab intersection block.
// Used by rbsi_comb and ray_box_slab_intersect; no dependencies.
package rbsi_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int NUM_AXES        = 3;
    localparam int DIST_WIDTH      = 31;
    localparam int CFG_IDX_WIDTH   = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_Z = 3'd5;

    // Per-item side info that travels beside the dividers
    typedef struct packed {
        logic                valid;
        logic [NUM_AXES-1:0] par;    // axis heading is zero
        logic                pmiss;  // origin outside a parallel slab
    } rbsi_side_t;

endpackage

FILE: hdl/rbsi_div.sv
// Pipelined restoring divider: (num << FB) / den, one quotient bit per stage,
// signed and saturated result. Depends on nothing but its parameters.
module rbsi_div #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [CW:0]          num_mag,
    input  logic [CW-1:0]        den_mag,
    input  logic                 neg,
    output logic signed [CW-1:0] quot
);
    localparam int NW = CW + 1 + FB;
    localparam logic [CW-1:0] CAP = {1'b1, {(CW-1){1'b0}}};

    logic [CW-1:0] rem_reg [0:CW];
    logic [CW-1:0] low_reg [0:CW];
    logic [CW-1:0] q_reg   [0:CW];
    logic [CW-1:0] den_reg [0:CW];
    logic          ovf_reg [0:CW];
    logic          neg_reg [0:CW];
    logic [NW-1:0] n_full;
    logic [NW-1:0] n_high;
    logic [CW-1:0] mag;
    logic [CW-1:0] quot_next;
    logic signed [CW-1:0] quot_reg;

    assign n_full = NW'(num_mag) << FB;
    assign n_high = n_full >> CW;

    // Check for overflow and load the integer remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= n_high >= NW'(den_mag);
            rem_reg[0] <= n_high[CW-1:0];
            low_reg[0] <= n_full[CW-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den_mag;
            neg_reg[0] <= neg;
        end
    end

    // One quotient bit per stage
    for (genvar k = 1; k <= CW; k++)
    begin : g_step
        logic [CW:0] trial;
        logic        ge;
        assign trial = {rem_reg[k-1], low_reg[k-1][CW-1]};
        assign ge    = trial >= {1'b0, den_reg[k-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? CW'(trial - {1'b0, den_reg[k-1]}) : trial[CW-1:0];
                low_reg[k] <= low_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][CW-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // Saturate and apply the sign
    always_comb
    begin
        mag = (ovf_reg[CW] || q_reg[CW] > CAP) ? CAP : q_reg[CW];
        if (neg_reg[CW])
            quot_next = CW'(-mag);
        else
            quot_next = (mag > CAP - 1'b1) ? CAP - 1'b1 : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quot_reg <= signed'(quot_next);
    end

    assign quot = quot_reg;
endmodule

FILE: hdl/rbsi_comb.sv
// Orders the per-axis distances, intersects the intervals and forms the
// result register. Depends on rbsi_pkg.
module rbsi_comb #(
    parameter int CW = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  rbsi_pkg::rbsi_side_t       side,
    input  logic signed [CW-1:0]       t_a [3],
    input  logic signed [CW-1:0]       t_b [3],
    output logic                       out_valid,
    output logic                       out_hit,
    output logic [rbsi_pkg::DIST_WIDTH-1:0] out_dist
);
    import rbsi_pkg::*;

    localparam int TW = CW + 2;
    localparam logic signed [TW-1:0] UNB  = TW'(1) << CW;
    localparam logic [63:0] DMAX = 64'((64'd1 << DIST_WIDTH) - 64'd1);

    rbsi_side_t         s1_reg, s2_reg;
    logic signed [CW-1:0] tmin_reg [NUM_AXES];
    logic signed [CW-1:0] tmax_reg [NUM_AXES];
    logic signed [TW-1:0] lo_reg, hi_reg, lo_next, hi_next;
    logic signed [TW-1:0] ext_min, ext_max, dist_sel;
    logic [63:0]          dist_wide;
    logic                 miss;
    logic                 valid_reg, hit_reg;
    logic [DIST_WIDTH-1:0] dist_reg;

    // Order each axis pair
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                tmin_reg[a] <= (t_a[a] > t_b[a]) ? t_b[a] : t_a[a];
                tmax_reg[a] <= (t_a[a] > t_b[a]) ? t_a[a] : t_b[a];
            end
        end
    end

    // Intersect the intervals of the non-parallel axes
    always_comb
    begin
        lo_next = -UNB;
        hi_next = UNB;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            ext_min = TW'(tmin_reg[a]);
            ext_max = TW'(tmax_reg[a]);
            if (!s1_reg.par[a])
            begin
                if (ext_min > lo_next)
                    lo_next = ext_min;
                if (ext_max < hi_next)
                    hi_next = ext_max;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // Decide hit and pick the nearest non-negative distance
    assign miss      = s2_reg.pmiss || lo_reg > hi_reg || hi_reg < 0;
    assign dist_sel  = (lo_reg >= 0) ? lo_reg : hi_reg;
    assign dist_wide = 64'($unsigned(dist_sel));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= !miss;
            dist_reg <= miss ? '0 :
                        (dist_wide > DMAX) ? DMAX[DIST_WIDTH-1:0] : dist_wide[DIST_WIDTH-1:0];
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= '0;
            s2_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_reg    <= side;
            s2_reg    <= s1_reg;
            valid_reg <= s2_reg.valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;
    assign out_dist  = dist_reg;
endmodule

FILE: hdl/ray_box_slab_intersect.sv
// Top level of the ray/box slab intersection block.
// Depends on rbsi_pkg, rbsi_div and rbsi_comb.
//
// Usage:
//   Write the six box corners through cfg_we/cfg_index/cfg_data while idle
//   (0..2 lower corner x,y,z, 3..5 upper corner x,y,z). Rays enter on the
//   s_* stream: tdata holds origin x,y,z then heading x,y,z, COORD_WIDTH
//   bits each. Each ray gives one result on the m_* stream: tuser[0] is
//   the hit flag, tdata the nearest non-negative distance (0 on miss).
//   Throughput: one ray per cycle unless the output stalls. Each ray passes
//   through the bit-per-stage dividers, six of which run side by side.
//   The whole pipeline advances as one: while m_tvalid is high and
//   m_tready low every stage holds and s_tready is low; nothing is lost.
//   Reset clears the box corners to zero and empties the pipeline.
module ray_box_slab_intersect #(
    parameter int COORD_WIDTH = rbsi_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = rbsi_pkg::DEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rbsi_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]       cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // origin_x, origin_y, origin_z, heading_x, heading_y, heading_z, pad
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // distance, pad
    output logic [31:0]                  m_tdata,
    // hit
    output logic [0:0]                   m_tuser
);
    import rbsi_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int LAT = CW + 2;

    logic signed [CW-1:0] bmin_reg [NUM_AXES];
    logic signed [CW-1:0] bmax_reg [NUM_AXES];
    logic signed [CW-1:0] org [NUM_AXES];
    logic signed [CW-1:0] hdg [NUM_AXES];
    logic [CW:0]          nmin_reg [NUM_AXES];
    logic [CW:0]          nmax_reg [NUM_AXES];
    logic                 sgmin_reg [NUM_AXES];
    logic                 sgmax_reg [NUM_AXES];
    logic [CW-1:0]        dmag_reg [NUM_AXES];
    logic signed [CW-1:0] t_a [NUM_AXES];
    logic signed [CW-1:0] t_b [NUM_AXES];
    rbsi_side_t           side_next;
    rbsi_side_t           side_reg [0:LAT];
    logic                 en;
    logic                 out_valid, out_hit;
    logic [DIST_WIDTH-1:0] out_dist;

    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    // Hold the box corners
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                bmin_reg[a] <= '0;
                bmax_reg[a] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_X: bmin_reg[0] <= cfg_data;
                REG_MIN_Y: bmin_reg[1] <= cfg_data;
                REG_MIN_Z: bmin_reg[2] <= cfg_data;
                REG_MAX_X: bmax_reg[0] <= cfg_data;
                REG_MAX_Y: bmax_reg[1] <= cfg_data;
                REG_MAX_Z: bmax_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the item and form per-axis numerators and heading magnitudes
    always_comb
    begin
        side_next.valid = s_tvalid;
        side_next.pmiss = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            org[a] = s_tdata[a*CW +: CW];
            hdg[a] = s_tdata[(a+3)*CW +: CW];
            side_next.par[a] = (hdg[a] == '0);
            if (side_next.par[a] && (org[a] < bmin_reg[a] || org[a] > bmax_reg[a]))
                side_next.pmiss = 1'b1;
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_prep
        logic signed [CW:0] dmin, dmax;
        assign dmin = (CW+1)'(bmin_reg[a]) - (CW+1)'(org[a]);
        assign dmax = (CW+1)'(bmax_reg[a]) - (CW+1)'(org[a]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nmin_reg[a]  <= dmin[CW] ? (CW+1)'(-dmin) : dmin;
                nmax_reg[a]  <= dmax[CW] ? (CW+1)'(-dmax) : dmax;
                sgmin_reg[a] <= dmin[CW] ^ hdg[a][CW-1];
                sgmax_reg[a] <= dmax[CW] ^ hdg[a][CW-1];
                dmag_reg[a]  <= hdg[a][CW-1] ? CW'(-hdg[a]) : hdg[a];
            end
        end

        rbsi_div #(.CW(CW), .FB(FRAC_BITS)) u_div_min (
            .clk     (clk),
            .en      (en),
            .num_mag (nmin_reg[a]),
            .den_mag (dmag_reg[a]),
            .neg     (sgmin_reg[a]),
            .quot    (t_a[a])
        );

        rbsi_div #(.CW(CW), .FB(FRAC_BITS)) u_div_max (
            .clk     (clk),
            .en      (en),
            .num_mag (nmax_reg[a]),
            .den_mag (dmag_reg[a]),
            .neg     (sgmax_reg[a]),
            .quot    (t_b[a])
        );
    end

    // Delay the side info alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAT; k++)
                side_reg[k] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    rbsi_comb #(.CW(CW)) u_comb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .side      (side_reg[LAT]),
        .t_a       (t_a),
        .t_b       (t_b),
        .out_valid (out_valid),
        .out_hit   (out_hit),
        .out_dist  (out_dist)
    );

    assign m_tvalid   = out_valid;
    assign m_tdata    = {1'b0, out_dist};
    assign m_tuser[0] = out_hit;

    // A miss reports zero distance
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss with nonzero distance");

    // The whole pipeline holds while the result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(side_reg[LAT]) && $stable(side_reg[0]))
        else $error("pipeline moved during stall");

    // A result appears only if an item was valid in the s2_reg stage of rbsi_comb
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(u_comb.s2_reg.valid))
        else $error("result without item");
endmodule

FILE: sim/tb_ray_box_slab_intersect.sv
// Testbench for ray_box_slab_intersect: directed and random rays against
// several box settings, each result checked against an in-bench slab predictor.
// Depends on rbsi_pkg and the ray_box_slab_intersect RTL.
`timescale 1ns / 1ps

module tb_ray_box_slab_intersect;
    import rbsi_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LATENCY = CW + 6;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        hit;
        logic [30:0] distance;
    } slab_result_t;

    typedef struct {
        logic [CW-1:0] org [3];
        logic [CW-1:0] dir [3];
        logic          known;  // expected result typed in below
        slab_result_t  res;
    } ray_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [CW-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [6*CW-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [31:0] m_tdata;
    logic [0:0] m_tuser;

    logic [CW-1:0] box_lo [3];
    logic [CW-1:0] box_hi [3];
    slab_result_t hit_queue [$];
    int  err_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    bit  hold_req;
    longint cycles;

    ray_box_slab_intersect u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Exact num * 2^FB / den, truncated toward zero, saturated to signed CW bits
    function automatic longint slab_quot(longint num, longint den);
        longint cap;
        bit neg;
        longint n;
        longint d;
        longint q;
        longint r;
        cap = longint'(1) << (CW - 1);
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n % d;
        if (q > (cap >> FB))
            q = cap;
        else
        begin
            for (int i = 0; i < FB; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 1;
                end
            end
            if (q > cap)
                q = cap;
        end
        if (neg)
            return -q;
        if (q > cap - 1)
            q = cap - 1;
        return q;
    endfunction

    function automatic slab_result_t predict_hit(logic [CW-1:0] org [3],
                                                 logic [CW-1:0] dir [3]);
        longint lo;
        longint hi;
        longint t1;
        longint t2;
        longint tmp;
        longint bmin;
        longint bmax;
        longint o;
        longint d;
        longint dist_val;
        bit miss;
        slab_result_t res;
        lo = -(longint'(1) << 62);
        hi = longint'(1) << 62;
        miss = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            bmin = longint'($signed(box_lo[a]));
            bmax = longint'($signed(box_hi[a]));
            o = longint'($signed(org[a]));
            d = longint'($signed(dir[a]));
            if (d == 0)
            begin
                if (o < bmin || o > bmax)
                    miss = 1'b1;
            end
            else
            begin
                t1 = slab_quot(bmin - o, d);
                t2 = slab_quot(bmax - o, d);
                if (t1 > t2)
                begin
                    tmp = t1;
                    t1 = t2;
                    t2 = tmp;
                end
                if (t1 > lo)
                    lo = t1;
                if (t2 < hi)
                    hi = t2;
            end
        end
        if (lo > hi || hi < 0)
            miss = 1'b1;
        res = '0;
        if (!miss)
        begin
            dist_val = (lo >= 0) ? lo : hi;
            res.hit = 1'b1;
            res.distance = (dist_val > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : dist_val[30:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Check results at the rising edge
    always @(posedge clk)
    begin
        slab_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (hit_queue.size() == 0)
                report_mismatch("unexpected result", {m_tuser, m_tdata}, 0);
            else
            begin
                want = hit_queue.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", m_tuser[0], want.hit);
                if (m_tdata !== {1'b0, want.distance})
                    report_mismatch("distance", m_tdata, want.distance);
            end
        end
    end

    // Drive the receiver ready at the falling edge
    always @(negedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_box(logic [CFG_IDX_WIDTH-1:0] idx, logic [CW-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx < REG_MAX_X)
            box_lo[idx] = val;
        else
            box_hi[idx - REG_MAX_X] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_box(logic [CW-1:0] lx, logic [CW-1:0] ly, logic [CW-1:0] lz,
                           logic [CW-1:0] hx, logic [CW-1:0] hy, logic [CW-1:0] hz);
        write_box(REG_MIN_X, lx);
        write_box(REG_MIN_Y, ly);
        write_box(REG_MIN_Z, lz);
        write_box(REG_MAX_X, hx);
        write_box(REG_MAX_Y, hy);
        write_box(REG_MAX_Z, hz);
    endtask

    // Offer one ray from a falling edge, hold until accepted
    task automatic send_ray(logic [CW-1:0] org [3], logic [CW-1:0] dir [3]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dir[2], dir[1], dir[0], org[2], org[1], org[0]};
        do
            @(posedge clk);
        while (!s_tready);
        hit_queue.push_back(predict_hit(org, dir));
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (hit_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(40 << FB) - (20 << FB);
            2: return $urandom_range(1 << FB);
            default: return $urandom_range(2000) - 1000;
        endcase
    endfunction

    // Random rays: mostly aimed near the box, some wild
    task automatic random_rays(int count);
        logic [CW-1:0] org [3];
        logic [CW-1:0] dir [3];
        int m;
        for (int k = 0; k < count; k++)
        begin
            m = $urandom_range(9);
            for (int a = 0; a < 3; a++)
            begin
                if (m < 2)
                begin
                    org[a] = rand_coord(0);
                    dir[a] = rand_coord(0);
                end
                else
                begin
                    org[a] = rand_coord(1);
                    dir[a] = ($urandom_range(7) == 0) ? '0 :
                             rand_coord($urandom_range(3, 1));
                end
            end
            send_ray(org, dir);
        end
    endtask

    localparam logic [CW-1:0] ONE = 32'h0001_0000;
    localparam logic [CW-1:0] MAXC = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] MINC = 32'h8000_0000;

    initial
    begin
        ray_row_t rows [$];
        ray_row_t r;
        int p;
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = '0;
            box_hi[a] = '0;
        end
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // After reset the box is the origin point: a ray from there touches it
        r.org = '{0, 0, 0};
        r.dir = '{ONE, ONE, ONE};
        r.known = 1'b1;
        r.res = '{1'b1, 31'd0};
        rows.push_back(r);
        // all axes parallel, inside: saturated distance
        r.dir = '{0, 0, 0};
        r.res = '{1'b1, 31'h7FFF_FFFF};
        rows.push_back(r);
        // parallel axis outside the slab: miss
        r.org = '{ONE, 0, 0};
        r.res = '{1'b0, 31'd0};
        rows.push_back(r);
        foreach (rows[i])
        begin
            send_ray(rows[i].org, rows[i].dir);
            if (rows[i].known && hit_queue[$] !== rows[i].res)
                report_mismatch("directed row", hit_queue[$], rows[i].res);
        end
        drain();

        // Unit box at 1..2: entry, inside, behind, touching, extremes, parallel
        set_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE);
        rows.delete();
        r.known = 1'b0;
        r.org = '{0, 0, 0};          r.dir = '{ONE, ONE, ONE};        rows.push_back(r);
        r.org = '{ONE + (ONE >> 1), ONE + (ONE >> 1), ONE + (ONE >> 1)};
        rows.push_back(r);
        r.org = '{3 * ONE, 3 * ONE, 3 * ONE};                         rows.push_back(r);
        r.org = '{0, 0, 0};          r.dir = '{-ONE, -ONE, -ONE};     rows.push_back(r);
        r.org = '{0, 0, 2 * ONE};    r.dir = '{ONE, ONE, -ONE};       rows.push_back(r);
        r.org = '{0, 0, 0};          r.dir = '{1, 1, 1};              rows.push_back(r);
        r.org = '{MINC, MINC, MINC}; r.dir = '{MAXC, MAXC, MAXC};     rows.push_back(r);
        r.org = '{MAXC, MAXC, MAXC}; r.dir = '{MINC, MINC, MINC};     rows.push_back(r);
        r.org = '{0, ONE, ONE};      r.dir = '{ONE, 0, 0};            rows.push_back(r);
        r.org = '{0, 3 * ONE, ONE};  r.dir = '{ONE, 0, 0};            rows.push_back(r);
        r.org = '{MAXC, 0, MINC};    r.dir = '{32'hFFFF_FFFF, MAXC, MINC};
        rows.push_back(r);
        foreach (rows[i])
            send_ray(rows[i].org, rows[i].dir);
        drain();

        // Swapped corners, then the extremes of the register range
        set_box(2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE);
        foreach (rows[i])
            send_ray(rows[i].org, rows[i].dir);
        drain();
        set_box(MINC, MINC, MINC, MAXC, MAXC, MAXC);
        foreach (rows[i])
            send_ray(rows[i].org, rows[i].dir);
        drain();

        // Random phases with box settings varied between them
        for (int ph = 0; ph < 5; ph++)
        begin
            p = ph % 4;
            send_idle_pct = (p == 1 || p == 3) ? ((p == 3) ? 38 : 65) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? ((p == 2) ? 65 : 38) : 0;
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 20;
                hold_req = 1'b1;
            end
            set_box(-($urandom_range(8) << FB), -($urandom_range(8) << FB),
                    -($urandom_range(8) << FB), $urandom_range(8) << FB,
                    $urandom_range(8) << FB, $urandom_range(8) << FB);
            random_rays(120);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        random_rays(40);
        drain();

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
